// File: sv/rmv_pkg.sv
// ----------------------------------------------------------------------------
// Running mean and variance unit: shared definitions
// Types, codes and widths used by the controller, the datapath and the
// checker of the running statistics unit.
// ----------------------------------------------------------------------------
package rmv_pkg;

    // Default parameter values for the top level.
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;

    // Fixed internal widths.
    localparam int SUM_W    = 32;   // saturating signed sum of samples
    localparam int SUMSQ_W  = 48;   // saturating unsigned sum of squares, Q48.0
    localparam int MAG2_W   = 64;   // square of the sum magnitude
    localparam int DIVD_W   = 64;   // dividend width of the shared divider
    localparam int ROOT_W   = 24;   // square root of a SUMSQ_W value
    localparam int Z_W      = 42;   // signed z-score before saturation
    localparam int Q_FRAC   = 8;    // fraction bits of a Q8.8 value

    // Result item fields.
    localparam int MEAN_W   = 16;
    localparam int VAR_W    = 32;
    localparam int STD_W    = 16;
    localparam int ZOUT_W   = 16;
    localparam int CNTOUT_W = 16;
    localparam int STAT_W   = 2;
    localparam int CMD_W    = 2;
    localparam int OUT_TDATA_W = MEAN_W + 2 * VAR_W + 2 * STD_W + ZOUT_W + CNTOUT_W;

    // Request commands; the unused code behaves as a query.
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_ONE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_FLAT  = 2'd3;

    // Operations of the shared divider.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_MEAN = 3'd0;  // |sum| / n
    localparam logic [OP_W-1:0] OP_S2   = 3'd1;  // sum^2 / n
    localparam logic [OP_W-1:0] OP_PV   = 3'd2;  // d / n
    localparam logic [OP_W-1:0] OP_SV   = 3'd3;  // d / (n - 1)
    localparam logic [OP_W-1:0] OP_SE   = 3'd4;  // pv / n
    localparam logic [OP_W-1:0] OP_Z    = 3'd5;  // |diff| * 256 / sd

    // Operand selects of the square root unit.
    localparam logic RT_SD = 1'b0;
    localparam logic RT_SE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            load_in;
        logic            do_sq;
        logic            do_acc;
        logic            do_mag2;
        logic            div_start;
        logic [OP_W-1:0] div_op;
        logic            rt_start;
        logic            rt_sel;
        logic            load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic rt_done;
        logic cnt_zero;
        logic cnt_one;
        logic sd_zero;
        logic out_free;
    } t_sts;

endpackage

// File: sv/rmv_ctrl.sv
// ----------------------------------------------------------------------------
// Running mean and variance unit: controller
// Sequences the accumulator update, up to six divisions and up to two square
// roots of one request, and hands the result to the output register.
// ----------------------------------------------------------------------------
module rmv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rmv_pkg::t_sts i_sts,
    output rmv_pkg::t_cmd o_cmd
);
    import rmv_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SQ     = 5'd1;
    localparam logic [4:0] S_ACC    = 5'd2;
    localparam logic [4:0] S_CHK    = 5'd3;
    localparam logic [4:0] S_I_MEAN = 5'd4;
    localparam logic [4:0] S_W_MEAN = 5'd5;
    localparam logic [4:0] S_I_S2   = 5'd6;
    localparam logic [4:0] S_W_S2   = 5'd7;
    localparam logic [4:0] S_I_PV   = 5'd8;
    localparam logic [4:0] S_W_PV   = 5'd9;
    localparam logic [4:0] S_I_SV   = 5'd10;
    localparam logic [4:0] S_W_SV   = 5'd11;
    localparam logic [4:0] S_I_SD   = 5'd12;
    localparam logic [4:0] S_W_SD   = 5'd13;
    localparam logic [4:0] S_I_SED  = 5'd14;
    localparam logic [4:0] S_W_SED  = 5'd15;
    localparam logic [4:0] S_I_SE   = 5'd16;
    localparam logic [4:0] S_W_SE   = 5'd17;
    localparam logic [4:0] S_I_Z    = 5'd18;
    localparam logic [4:0] S_W_Z    = 5'd19;
    localparam logic [4:0] S_OUT    = 5'd20;

    logic [4:0] r_state;
    logic [4:0] n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.do_sq = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                o_cmd.do_acc = 1'b1;
                n_state      = S_CHK;
            end
            S_CHK: begin
                o_cmd.do_mag2 = 1'b1;
                n_state       = i_sts.cnt_zero ? S_OUT : S_I_MEAN;
            end
            S_I_MEAN: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_MEAN;
                n_state         = S_W_MEAN;
            end
            S_W_MEAN: begin
                if (i_sts.div_done) begin
                    n_state = S_I_S2;
                end
            end
            S_I_S2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_S2;
                n_state         = S_W_S2;
            end
            S_W_S2: begin
                if (i_sts.div_done) begin
                    n_state = S_I_PV;
                end
            end
            S_I_PV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_PV;
                n_state         = S_W_PV;
            end
            S_W_PV: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.cnt_one ? S_I_SD : S_I_SV;
                end
            end
            S_I_SV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_SV;
                n_state         = S_W_SV;
            end
            S_W_SV: begin
                if (i_sts.div_done) begin
                    n_state = S_I_SD;
                end
            end
            S_I_SD: begin
                o_cmd.rt_start = 1'b1;
                o_cmd.rt_sel   = RT_SD;
                n_state        = S_W_SD;
            end
            S_W_SD: begin
                if (i_sts.rt_done) begin
                    n_state = S_I_SED;
                end
            end
            S_I_SED: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_SE;
                n_state         = S_W_SED;
            end
            S_W_SED: begin
                if (i_sts.div_done) begin
                    n_state = S_I_SE;
                end
            end
            S_I_SE: begin
                o_cmd.rt_start = 1'b1;
                o_cmd.rt_sel   = RT_SE;
                n_state        = S_W_SE;
            end
            S_W_SE: begin
                if (i_sts.rt_done) begin
                    n_state = (i_sts.cnt_one || i_sts.sd_zero) ? S_OUT : S_I_Z;
                end
            end
            S_I_Z: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_Z;
                n_state         = S_W_Z;
            end
            S_W_Z: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Wait until the output register is free to take the result.
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/rmv_dp.sv
// ----------------------------------------------------------------------------
// Running mean and variance unit: datapath
// Accumulators, a shared bit-serial divider, a bit-pair square root unit and
// the output register with result formatting and saturation.
// ----------------------------------------------------------------------------
module rmv_dp #(
    parameter int SAMPLE_BITS = rmv_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = rmv_pkg::COUNT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rmv_pkg::t_cmd                      i_cmd,
    output rmv_pkg::t_sts                      o_sts,
    input  logic [rmv_pkg::CMD_W-1:0]          i_in_cmd,
    input  logic signed [SAMPLE_BITS-1:0]      i_in_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [rmv_pkg::OUT_TDATA_W-1:0]    o_out_data,
    output logic [rmv_pkg::STAT_W-1:0]         o_out_status
);
    import rmv_pkg::*;

    localparam int DIV_W  = (COUNT_BITS > ROOT_W) ? COUNT_BITS : ROOT_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int ACC_W  = ((SQ_W > SUMSQ_W) ? SQ_W : SUMSQ_W) + 1;
    localparam int SUM_XW = SUM_W + 1;
    localparam int DIFF_W = SUM_W + 2;
    localparam int DCNT_W = $clog2(DIVD_W);

    // Saturate a signed value to the signed Q8.8 range.
    function automatic logic [ZOUT_W-1:0] sat_s16(input logic signed [Z_W-1:0] x);
        logic fits;
        fits = (&x[Z_W-1:ZOUT_W-1]) || !(|x[Z_W-1:ZOUT_W-1]);
        if (fits) begin
            return x[ZOUT_W-1:0];
        end else begin
            return x[Z_W-1] ? {1'b1, {(ZOUT_W-1){1'b0}}} : {1'b0, {(ZOUT_W-1){1'b1}}};
        end
    endfunction

    // Request registers.
    logic [CMD_W-1:0]              r_in_cmd;
    logic signed [SAMPLE_BITS-1:0] r_value;
    logic [SQ_W-1:0]               r_sq;

    // Accumulators.
    logic signed [SUM_W-1:0] r_sum;
    logic [SUMSQ_W-1:0]      r_sumsq;
    logic [COUNT_BITS-1:0]   r_count;

    // Intermediate results.
    logic [MAG2_W-1:0]       r_mag2;
    logic signed [SUM_W-1:0] r_mean;
    logic [MAG2_W-1:0]       r_s2;
    logic [SUMSQ_W-1:0]      r_pv;
    logic [SUMSQ_W-1:0]      r_sv;
    logic [SUMSQ_W-1:0]      r_pvn;
    logic [ROOT_W-1:0]       r_sd;
    logic [ROOT_W-1:0]       r_se;
    logic signed [Z_W-1:0]   r_z;

    // Divider.
    logic              r_div_busy;
    logic              r_div_done;
    logic [DCNT_W-1:0] r_div_cnt;
    logic [OP_W-1:0]   r_div_op;
    logic [DIVD_W-1:0] r_quo;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_den;

    // Square root unit.
    logic               r_rt_busy;
    logic               r_rt_done;
    logic               r_rt_sel;
    logic [SUMSQ_W-1:0] r_rt_x;
    logic [SUMSQ_W-1:0] r_rt_res;
    logic [SUMSQ_W-1:0] r_rt_bit;

    // Output register.
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [STAT_W-1:0]      r_out_status;

    logic [SAMPLE_BITS-1:0]   w_vmag;
    logic signed [SUM_XW-1:0] w_sum_ext;
    logic [SUM_W-1:0]         w_sum_sat;
    logic [ACC_W-1:0]         w_sq_tot;
    logic                     w_add_ok;
    logic                     w_sum_neg;
    logic [SUM_W-1:0]         w_sum_mag;
    logic [SUMSQ_W-1:0]       w_d;
    logic signed [DIFF_W-1:0] w_diff;
    logic [DIFF_W-1:0]        w_diff_mag;
    logic [COUNT_BITS-1:0]    w_cnt_m1;
    logic [DIVD_W-1:0]        w_dvd;
    logic [DIV_W-1:0]         w_dvs;
    logic [DIV_W:0]           w_rem_sh;
    logic                     w_rem_ge;
    logic [DIV_W:0]           w_rem_sub;
    logic [SUMSQ_W-1:0]       w_rt_trial;
    logic                     w_rt_ge;
    logic                     w_cnt_zero;
    logic                     w_cnt_one;
    logic                     w_sd_zero;
    logic [MEAN_W-1:0]        w_f_mean;
    logic [VAR_W-1:0]         w_f_pv;
    logic [VAR_W-1:0]         w_f_sv;
    logic [STD_W-1:0]         w_f_sd;
    logic [STD_W-1:0]         w_f_se;
    logic [ZOUT_W-1:0]        w_f_z;
    logic [CNTOUT_W-1:0]      w_f_cnt;
    logic [STAT_W-1:0]        w_f_stat;

    // Sample magnitude and the saturating accumulator sums.
    assign w_vmag    = r_value[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_value) : SAMPLE_BITS'(r_value);
    assign w_sum_ext = SUM_XW'(r_sum) + SUM_XW'(r_value);
    assign w_sum_sat = (w_sum_ext[SUM_W] != w_sum_ext[SUM_W-1])
                     ? (w_sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}})
                     : w_sum_ext[SUM_W-1:0];
    assign w_sq_tot  = ACC_W'(r_sumsq) + ACC_W'(r_sq);
    assign w_add_ok  = (r_in_cmd == CMD_ADD) && !(&r_count);

    // Operands of the statistics.
    assign w_sum_neg  = r_sum[SUM_W-1];
    assign w_sum_mag  = w_sum_neg ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_d        = (r_s2 > MAG2_W'(r_sumsq)) ? '0 : r_sumsq - r_s2[SUMSQ_W-1:0];
    assign w_diff     = DIFF_W'(r_value) - DIFF_W'(r_mean);
    assign w_diff_mag = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);
    assign w_cnt_m1   = r_count - COUNT_BITS'(1);

    // Dividend and divisor of the requested division.
    always_comb begin
        case (i_cmd.div_op) inside
            OP_MEAN:      w_dvd = DIVD_W'(w_sum_mag);
            OP_S2:        w_dvd = r_mag2;
            OP_PV, OP_SV: w_dvd = DIVD_W'(w_d);
            OP_SE:        w_dvd = DIVD_W'(r_pv);
            OP_Z:         w_dvd = DIVD_W'(w_diff_mag) << Q_FRAC;
            default:      w_dvd = '0;
        endcase
        case (i_cmd.div_op)
            OP_SV:   w_dvs = DIV_W'(w_cnt_m1);
            OP_Z:    w_dvs = DIV_W'(r_sd);
            default: w_dvs = DIV_W'(r_count);
        endcase
    end

    // Request capture, squaring and accumulator update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_cmd <= i_in_cmd;
            r_value  <= i_in_value;
        end
        if (i_cmd.do_sq) begin
            r_sq <= SQ_W'(w_vmag) * SQ_W'(w_vmag);
        end
        if (i_cmd.do_mag2) begin
            r_mag2 <= MAG2_W'(w_sum_mag) * MAG2_W'(w_sum_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_sumsq <= '0;
            r_count <= '0;
        end else if (i_cmd.do_acc) begin
            if (r_in_cmd == CMD_CLEAR) begin
                r_sum   <= '0;
                r_sumsq <= '0;
                r_count <= '0;
            end else if (w_add_ok) begin
                r_sum   <= w_sum_sat;
                r_sumsq <= (|w_sq_tot[ACC_W-1:SUMSQ_W]) ? '1 : w_sq_tot[SUMSQ_W-1:0];
                r_count <= r_count + COUNT_BITS'(1);
            end
        end
    end

    // Restoring divider, one quotient bit a cycle.
    assign w_rem_sh  = {r_rem, r_quo[DIVD_W-1]};
    assign w_rem_ge  = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
        end else begin
            r_div_done <= r_div_busy && (r_div_cnt == '0);
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
            end else if (r_div_busy && (r_div_cnt == '0)) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_op  <= i_cmd.div_op;
            r_div_cnt <= DCNT_W'(DIVD_W - 1);
            r_quo     <= w_dvd;
            r_rem     <= '0;
            r_den     <= w_dvs;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt - DCNT_W'(1);
            r_quo     <= {r_quo[DIVD_W-2:0], w_rem_ge};
            r_rem     <= w_rem_ge ? w_rem_sub[DIV_W-1:0] : w_rem_sh[DIV_W-1:0];
        end
    end

    // Quotient write-back by operation.
    always_ff @(posedge i_clk) begin
        if (r_div_done) begin
            case (r_div_op)
                OP_MEAN: r_mean <= w_sum_neg ? -SUM_W'(r_quo) : SUM_W'(r_quo);
                OP_S2:   r_s2   <= r_quo;
                OP_PV:   r_pv   <= SUMSQ_W'(r_quo);
                OP_SV:   r_sv   <= SUMSQ_W'(r_quo);
                OP_SE:   r_pvn  <= SUMSQ_W'(r_quo);
                OP_Z:    r_z    <= w_diff[DIFF_W-1] ? -Z_W'(r_quo) : Z_W'(r_quo);
                default: ;
            endcase
        end
    end

    // Integer square root, one result bit a cycle.
    assign w_rt_trial = r_rt_res + r_rt_bit;
    assign w_rt_ge    = (r_rt_x >= w_rt_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_busy <= 1'b0;
            r_rt_done <= 1'b0;
        end else begin
            r_rt_done <= r_rt_busy && (r_rt_bit == SUMSQ_W'(1));
            if (i_cmd.rt_start) begin
                r_rt_busy <= 1'b1;
            end else if (r_rt_busy && (r_rt_bit == SUMSQ_W'(1))) begin
                r_rt_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rt_start) begin
            r_rt_sel <= i_cmd.rt_sel;
            r_rt_x   <= (i_cmd.rt_sel == RT_SE) ? r_pvn : r_pv;
            r_rt_res <= '0;
            r_rt_bit <= SUMSQ_W'(1) << (SUMSQ_W - 2);
        end else if (r_rt_busy) begin
            if (w_rt_ge) begin
                r_rt_x   <= r_rt_x - w_rt_trial;
                r_rt_res <= (r_rt_res >> 1) + r_rt_bit;
            end else begin
                r_rt_res <= r_rt_res >> 1;
            end
            r_rt_bit <= r_rt_bit >> 2;
        end
        if (r_rt_done) begin
            if (r_rt_sel == RT_SE) begin
                r_se <= ROOT_W'(r_rt_res);
            end else begin
                r_sd <= ROOT_W'(r_rt_res);
            end
        end
    end

    // Result formatting and special cases.
    assign w_cnt_zero = (r_count == '0);
    assign w_cnt_one  = (r_count == COUNT_BITS'(1));
    assign w_sd_zero  = (r_sd == '0);

    always_comb begin
        w_f_mean = sat_s16(Z_W'(r_mean));
        w_f_pv   = (|r_pv[SUMSQ_W-1:VAR_W]) ? '1 : r_pv[VAR_W-1:0];
        w_f_sv   = (|r_sv[SUMSQ_W-1:VAR_W]) ? '1 : r_sv[VAR_W-1:0];
        w_f_sd   = (|r_sd[ROOT_W-1:STD_W]) ? '1 : r_sd[STD_W-1:0];
        w_f_se   = (|r_se[ROOT_W-1:STD_W]) ? '1 : r_se[STD_W-1:0];
        w_f_z    = sat_s16(r_z);
        w_f_cnt  = (32'(r_count) > 32'(16'hFFFF)) ? '1 : CNTOUT_W'(r_count);
        w_f_stat = ST_OK;
        if (w_cnt_zero) begin
            w_f_mean = '0;
            w_f_pv   = '0;
            w_f_sv   = '0;
            w_f_sd   = '0;
            w_f_se   = '0;
            w_f_z    = '0;
            w_f_cnt  = '0;
            w_f_stat = ST_EMPTY;
        end else if (w_cnt_one) begin
            w_f_sv   = '0;
            w_f_z    = '0;
            w_f_stat = ST_ONE;
        end else if (w_sd_zero) begin
            w_f_z    = '0;
            w_f_stat = ST_FLAT;
        end
    end

    // Output register; it frees when the downstream side takes the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data   <= {w_f_cnt, w_f_z, w_f_se, w_f_sd, w_f_sv, w_f_pv, w_f_mean};
            r_out_status <= w_f_stat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_status = r_out_status;

    // Status towards the controller.
    assign o_sts.div_done = r_div_done;
    assign o_sts.rt_done  = r_rt_done;
    assign o_sts.cnt_zero = w_cnt_zero;
    assign o_sts.cnt_one  = w_cnt_one;
    assign o_sts.sd_zero  = w_sd_zero;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

// File: sv/running_mean_variance_unit_top.sv
// ----------------------------------------------------------------------------
// Running mean and variance unit: top level
// Every request (add, clear or query) returns one result with mean,
// variances, deviation, standard error and z-score; an add first updates
// the running sum, sum of squares and count, and a clear resets them. With a
// single sample the sample variance and z-score divisions are skipped. With
// zero deviation only the z-score division is skipped. When the count is zero
// all divisions and square roots are skipped. A request runs up to six
// 64-bit divisions on one shared divider at one quotient bit a cycle, plus
// up to two 24-step square roots. One request is processed at a
// time. The next request is accepted while the previous result still waits
// in the output register. A result that is still waiting when the next one
// is ready holds the unit until the downstream side takes it.
// ----------------------------------------------------------------------------
module running_mean_variance_unit_top #(
    parameter int SAMPLE_BITS = rmv_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = rmv_pkg::COUNT_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // sample_value
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // command
    input  logic [rmv_pkg::CMD_W-1:0]               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // mean_value, population_variance, sample_variance, std_deviation,
    // std_error, z_score, sample_count
    output logic [rmv_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // status
    output logic [rmv_pkg::STAT_W-1:0]              m_axis_tuser
);
    import rmv_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    rmv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Accumulators and arithmetic.
    rmv_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_cmd     (s_axis_tuser),
        .i_in_value   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser)
    );

endmodule

// File: sv/rmv_checker.sv
// ----------------------------------------------------------------------------
// Running mean and variance unit: port checker
// Watches the top level's ports for the one-at-a-time request flow and the
// consistency of the result fields with the reported status.
// ----------------------------------------------------------------------------
module rmv_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              i_s_tready,
    input logic                              i_m_tvalid,
    input logic                              i_m_tready,
    input logic [rmv_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    input logic [rmv_pkg::STAT_W-1:0]        i_m_tuser
);
    import rmv_pkg::*;

    // A held result keeps its contents.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result changed while stalled");

    // After a request is taken, the unit is not ready in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("request accepted while busy");

    // With no samples every field is zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser == ST_EMPTY) |-> (i_m_tdata == '0))
        else $error("empty result carries data");

    // With one sample the count is one and the sample variance and score are zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser == ST_ONE) |->
            (i_m_tdata[79:48] == '0) && (i_m_tdata[127:112] == '0)
            && (i_m_tdata[143:128] == 16'd1))
        else $error("single sample result inconsistent");

    // A flat distribution gives a zero score and zero deviation.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser == ST_FLAT) |->
            (i_m_tdata[127:112] == '0) && (i_m_tdata[95:80] == '0))
        else $error("zero deviation result inconsistent");

endmodule

bind running_mean_variance_unit_top rmv_checker u_rmv_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
